@@ hdl/srf_pkg.sv @@
`default_nettype none
package srf_pkg;

  // command codes
  typedef enum logic [2:0] {
    MODE_CLEAR  = 3'd0,
    MODE_LINE   = 3'd1,
    MODE_RECT   = 3'd2,
    MODE_CIRCLE = 3'd3,
    MODE_TRI    = 3'd4,
    MODE_READ   = 3'd5,
    MODE_NOP6   = 3'd6,
    MODE_NOP7   = 3'd7
  } mode_t;

  localparam int unsigned CoordW = 11;
  localparam int unsigned WorkW  = 14;

  // one drawing job handed from the front to the back
  typedef enum logic [1:0] {
    JOB_LINE   = 2'd0,
    JOB_CIRCLE = 2'd1,
    JOB_CLEAR  = 2'd2,
    JOB_READ   = 2'd3
  } job_kind_t;

  typedef struct packed {
    job_kind_t                kind;
    logic                     last;
    logic signed [CoordW-1:0] c0;
    logic signed [CoordW-1:0] r0;
    logic signed [CoordW-1:0] c1;
    logic signed [CoordW-1:0] r1;
    logic [4:0]               rrow;
  } job_t;

  typedef enum logic [1:0] {
    FR_IDLE = 2'd0,
    FR_EMIT = 2'd1
  } front_state_t;

  typedef enum logic [2:0] {
    BK_IDLE   = 3'd0,
    BK_LINE   = 3'd1,
    BK_CIRC   = 3'd2,
    BK_CLEAR  = 3'd3,
    BK_READ   = 3'd4,
    BK_RDWAIT = 3'd5,
    BK_DONE   = 3'd6
  } back_state_t;

endpackage
`default_nettype wire

@@ hdl/shape_rasterizer_framebuffer.sv @@
// Rasterizer over a 1-bit canvas (CANVAS_ROWS x CANVAS_COLS). Commands: clear, line,
// rectangle, circle, triangle, read row, no-op; each gives one result. The front takes a
// command, then splits it into line/circle/clear/read jobs (four lines for a rectangle,
// three for a triangle) pushed into a 4-entry queue; full is high while it does so or
// waits on a full queue. The back walks one pixel (line) or one octant point (circle)
// per cycle as a read-modify-write on a row RAM with one read and one write port; the
// write still in flight is forwarded, so plots go back to back. Per job the back picks
// it up while idle, then walks a line to its end point, walks a circle in steps of eight
// octant points (about 0.71*r+1 steps), clears every row in turn, or reads the row through
// the registered RAM read; a negative radius goes straight to done. The result is
// registered, so empty drops in the cycle after the back pushes it. After reset the back
// zeroes the canvas in a clear pass; commands are accepted meanwhile and wait in the queue.
`default_nettype none
module shape_rasterizer_framebuffer
  import srf_pkg::*;
#(
  parameter int unsigned CANVAS_ROWS = 32,
  parameter int unsigned CANVAS_COLS = 64
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     push,
  output logic                          full,
  input  wire logic [2:0]               in_mode,
  input  wire logic signed [CoordW-1:0] in_first_col,
  input  wire logic signed [CoordW-1:0] in_first_row,
  input  wire logic signed [CoordW-1:0] in_second_col,
  input  wire logic signed [CoordW-1:0] in_second_row,
  input  wire logic signed [CoordW-1:0] in_third_col,
  input  wire logic signed [CoordW-1:0] in_third_row,
  input  wire logic signed [CoordW-1:0] in_radius,
  input  wire logic [4:0]               in_read_row,
  output logic                          empty,
  input  wire logic                     pop,
  output logic [63:0]                   out_row_pixels,
  output logic                          out_done_res
);
  logic cmd_ready, q_push, q_full, q_pop, q_empty, res_push, res_full;
  job_t q_in, q_head;
  logic [63:0] res_pixels;
  logic [63:0] out_r;
  logic out_v_r;
  logic [63:0] ref_pixels;

  assign full = !cmd_ready;

  srf_front u_front (
    .clk, .rst_n, .cmd_valid(push), .cmd_ready,
    .mode(in_mode), .c1(in_first_col), .r1(in_first_row), .c2(in_second_col),
    .r2(in_second_row), .c3(in_third_col), .r3(in_third_row), .rad(in_radius),
    .rrow(in_read_row), .q_push, .q_full, .q_job(q_in)
  );

  srf_fifo u_fifo (
    .clk, .rst_n, .push(q_push), .push_job(q_in), .full(q_full),
    .pop(q_pop), .head(q_head), .empty(q_empty)
  );

  srf_back #(.ROWS(CANVAS_ROWS), .COLS(CANVAS_COLS)) u_back (
    .clk, .rst_n, .job(q_head), .job_empty(q_empty), .job_pop(q_pop),
    .res_push, .res_pixels, .res_full
  );

  // column mask keeps bits past the canvas width at zero
  assign ref_pixels = res_pixels & ((CANVAS_COLS >= 64) ? ~64'd0
                                    : ((64'd1 << CANVAS_COLS) - 64'd1));

  // result register
  assign res_full = out_v_r && !pop;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (res_push) begin
      out_v_r <= 1'b1;
    end else if (pop) begin
      out_v_r <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (res_push) out_r <= ref_pixels;
  end

  assign empty          = !out_v_r;
  assign out_row_pixels = out_r;
  assign out_done_res   = 1'b1;

  assert property (@(posedge clk) disable iff (!rst_n) (out_v_r && !pop) |=> out_v_r)
    else $error("result dropped");
  assert property (@(posedge clk) disable iff (!rst_n) res_push |-> !(out_v_r && !pop))
    else $error("result overwritten");
  assert property (@(posedge clk) disable iff (!rst_n) res_push |=> !empty)
    else $error("result not shown");
endmodule
`default_nettype wire

@@ hdl/srf_ram.sv @@
`default_nettype none
module srf_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // one write and one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ hdl/srf_front.sv @@
`default_nettype none
module srf_front
  import srf_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cmd_valid,
  output logic                          cmd_ready,
  input  wire logic [2:0]               mode,
  input  wire logic signed [CoordW-1:0] c1,
  input  wire logic signed [CoordW-1:0] r1,
  input  wire logic signed [CoordW-1:0] c2,
  input  wire logic signed [CoordW-1:0] r2,
  input  wire logic signed [CoordW-1:0] c3,
  input  wire logic signed [CoordW-1:0] r3,
  input  wire logic signed [CoordW-1:0] rad,
  input  wire logic [4:0]               rrow,
  output logic                          q_push,
  input  wire logic                     q_full,
  output job_t                          q_job
);
  front_state_t state_r, state_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic [2:0] mode_r;
  logic signed [CoordW-1:0] c1_r, r1_r, c2_r, r2_r, c3_r, r3_r, rad_r;
  logic [4:0] rrow_r;
  logic [1:0] nlast;
  logic cmd_take;

  assign cmd_take = cmd_valid && cmd_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      FR_IDLE: begin
        if (cmd_take) begin
          state_nxt = FR_EMIT;
          idx_nxt   = 2'd0;
        end
      end
      FR_EMIT: begin
        if (!q_full) begin
          if (idx_r == nlast) begin
            state_nxt = FR_IDLE;
          end else begin
            idx_nxt = idx_r + 2'd1;
          end
        end
      end
      default: state_nxt = FR_IDLE;
    endcase
  end

  // how many jobs a command splits into, minus one
  always_comb begin
    case (mode_r)
      MODE_RECT: nlast = 2'd3;
      MODE_TRI:  nlast = 2'd2;
      default:   nlast = 2'd0;
    endcase
  end

  // outputs: job for the current piece
  always_comb begin
    cmd_ready    = (state_r == FR_IDLE);
    q_push       = (state_r == FR_EMIT) && !q_full;
    q_job        = '0;
    q_job.last   = (idx_r == nlast);
    q_job.rrow   = rrow_r;
    q_job.kind   = JOB_LINE;
    q_job.c0     = c1_r;
    q_job.r0     = r1_r;
    q_job.c1     = c2_r;
    q_job.r1     = r2_r;
    unique case (mode_r)
      MODE_CLEAR:  q_job.kind = JOB_CLEAR;
      MODE_LINE:   q_job.kind = JOB_LINE;
      MODE_CIRCLE: begin
        q_job.kind = JOB_CIRCLE;
        q_job.c1   = rad_r;
      end
      MODE_READ:   q_job.kind = JOB_READ;
      MODE_RECT: begin
        case (idx_r)
          2'd0: begin q_job.r1 = r1_r; end
          2'd1: begin q_job.r0 = r2_r; end
          2'd2: begin q_job.c1 = c1_r; end
          default: begin q_job.c0 = c2_r; end
        endcase
      end
      MODE_TRI: begin
        case (idx_r)
          2'd0: ;
          2'd1: begin
            q_job.c0 = c2_r; q_job.r0 = r2_r; q_job.c1 = c3_r; q_job.r1 = r3_r;
          end
          default: begin
            q_job.c0 = c3_r; q_job.r0 = r3_r; q_job.c1 = c1_r; q_job.r1 = r1_r;
          end
        endcase
      end
      default: begin
        // no-op: a read job marked invalid (c0 nonzero) returns zero
        q_job.kind = JOB_READ;
        q_job.rrow = 5'd31;
        q_job.c0   = 11'sd1;
      end
    endcase
    if (mode_r == MODE_READ) begin
      q_job.c0 = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FR_IDLE;
      idx_r   <= 2'd0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // command capture
  always_ff @(posedge clk) begin
    if (cmd_take) begin
      mode_r <= mode; c1_r <= c1; r1_r <= r1; c2_r <= c2; r2_r <= r2;
      c3_r <= c3; r3_r <= r3; rad_r <= rad; rrow_r <= rrow;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) q_push |-> state_r == FR_EMIT)
    else $error("push outside emit");
  assert property (@(posedge clk) disable iff (!rst_n) cmd_take |=> state_r == FR_EMIT)
    else $error("command not expanded");
  assert property (@(posedge clk) disable iff (!rst_n) (state_r == FR_EMIT) |-> idx_r <= nlast)
    else $error("piece index overrun");
endmodule
`default_nettype wire

@@ hdl/srf_fifo.sv @@
`default_nettype none
module srf_fifo
  import srf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_job,
  output logic      full,
  input  wire logic pop,
  output job_t      head,
  output logic      empty
);
  localparam int unsigned Depth = 4;
  job_t slot_r [Depth];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;

  assign full  = (cnt_r == 3'(Depth));
  assign empty = (cnt_r == 3'd0);
  assign head  = slot_r[rp_r];

  // pointer and count update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push && !full) wp_r <= wp_r + 2'd1;
      if (pop && !empty) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + 3'(push && !full) - 3'(pop && !empty);
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) slot_r[wp_r] <= push_job;
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 3'(Depth))
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (!rst_n) full |-> !empty)
    else $error("queue full and empty");
  assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !empty && !(push && !full)) |=> !full) else $error("pop left queue full");
endmodule
`default_nettype wire

@@ hdl/srf_back.sv @@
`default_nettype none
module srf_back
  import srf_pkg::*;
#(
  parameter int unsigned ROWS = 32,
  parameter int unsigned COLS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire job_t        job,
  input  wire logic        job_empty,
  output logic             job_pop,
  output logic             res_push,
  output logic [63:0]      res_pixels,
  input  wire logic        res_full
);
  localparam int unsigned AW = (ROWS > 1) ? $clog2(ROWS) : 1;

  back_state_t state_r, state_nxt;
  // line walker
  logic signed [WorkW-1:0] lc_r, lr_r, lc1_r, lr1_r, dc_r, dr_r, err_r;
  logic sc_r, sr_r;
  // circle walker
  logic signed [WorkW-1:0] cx_r, cy_r, cd_r, ccc_r, ccr_r;
  logic [2:0] oct_r;
  // read-modify-write pipeline for pixel plots
  logic [AW:0] clr_r;
  logic        last_r;
  logic [4:0]  rrow_r;
  logic        rdbad_r;

  logic signed [WorkW-1:0] pr, pc;
  logic pvalid;
  logic [AW-1:0] raddr, waddr;
  logic [63:0] rdata, wdata;
  logic we;
  // plot pipeline: stage 1 holds address while ram reads
  logic          p1_v_r;
  logic [AW-1:0] p1_row_r;
  logic [5:0]    p1_col_r;
  logic          fwd_hit;
  logic [63:0]   lastw_r;
  logic          lastw_v_r;
  logic [AW-1:0] lastw_row_r;
  logic [63:0]   base;

  srf_ram #(.WIDTH(64), .DEPTH(1 << AW)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // current plot point of the walker
  always_comb begin
    pr = lr_r; pc = lc_r;
    if (state_r == BK_CIRC) begin
      case (oct_r)
        3'd0: begin pr = ccr_r + cy_r; pc = ccc_r + cx_r; end
        3'd1: begin pr = ccr_r - cy_r; pc = ccc_r + cx_r; end
        3'd2: begin pr = ccr_r + cy_r; pc = ccc_r - cx_r; end
        3'd3: begin pr = ccr_r - cy_r; pc = ccc_r - cx_r; end
        3'd4: begin pr = ccr_r + cx_r; pc = ccc_r + cy_r; end
        3'd5: begin pr = ccr_r - cx_r; pc = ccc_r + cy_r; end
        3'd6: begin pr = ccr_r + cx_r; pc = ccc_r - cy_r; end
        default: begin pr = ccr_r - cx_r; pc = ccc_r - cy_r; end
      endcase
    end
    pvalid = ((state_r == BK_LINE) || (state_r == BK_CIRC && cx_r <= cy_r))
             && pr >= 0 && pr < WorkW'(ROWS) && pc >= 0 && pc < WorkW'(COLS);
  end

  // ram port steering, the read row is held until the result leaves
  always_comb begin
    raddr = pr[AW-1:0];
    if (state_r == BK_READ || state_r == BK_RDWAIT || state_r == BK_DONE) begin
      raddr = rrow_r[AW-1:0];
    end
    fwd_hit = lastw_v_r && (lastw_row_r == p1_row_r);
    base    = fwd_hit ? lastw_r : rdata;
    we    = 1'b0;
    waddr = p1_row_r;
    wdata = base | (64'd1 << p1_col_r);
    if (state_r == BK_CLEAR) begin
      we = 1'b1; waddr = clr_r[AW-1:0]; wdata = '0;
    end else if (p1_v_r) begin
      we = 1'b1;
    end
  end

  logic signed [WorkW:0] e2;
  logic line_end, circ_end, step_ok;
  assign e2 = {err_r, 1'b0};
  assign line_end = (lc_r == lc1_r) && (lr_r == lr1_r);
  assign circ_end = (cx_r > cy_r);
  // walker steps every cycle, the write still in flight is forwarded
  assign step_ok = 1'b1;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: if (!job_empty) begin
        unique case (job.kind)
          JOB_LINE:   state_nxt = BK_LINE;
          JOB_CIRCLE: state_nxt = (job.c1 < 0) ? BK_DONE : BK_CIRC;
          JOB_CLEAR:  state_nxt = BK_CLEAR;
          default:    state_nxt = BK_READ;
        endcase
      end
      BK_LINE:   if (line_end) state_nxt = BK_DONE;
      BK_CIRC:   if (circ_end) state_nxt = BK_DONE;
      BK_CLEAR:  if (clr_r == (AW+1)'(ROWS - 1)) state_nxt = BK_DONE;
      BK_READ:   state_nxt = BK_RDWAIT;
      BK_RDWAIT: state_nxt = BK_DONE;
      BK_DONE:   if (!last_r || !res_full) state_nxt = BK_IDLE;
      default:   state_nxt = BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    job_pop    = (state_r == BK_IDLE) && !job_empty;
    res_push   = (state_r == BK_DONE) && last_r && !res_full && !p1_v_r;
    res_pixels = (rdbad_r) ? 64'd0 : rdata;
  end

  // reset starts with a clear walk over every row
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_CLEAR; p1_v_r <= 1'b0; lastw_v_r <= 1'b0;
    end else begin
      if (!(state_r == BK_DONE && p1_v_r)) state_r <= state_nxt;
      p1_v_r    <= pvalid;
      lastw_v_r <= p1_v_r;
    end
  end

  // walker datapath
  always_ff @(posedge clk) begin
    p1_row_r <= pr[AW-1:0];
    p1_col_r <= pc[5:0];
    lastw_r  <= wdata;
    lastw_row_r <= p1_row_r;
    if (!rst_n) begin
      clr_r  <= '0;
      last_r <= 1'b0;
    end else if (job_pop) begin
      last_r  <= job.last;
      rrow_r  <= job.rrow;
      rdbad_r <= (job.kind != JOB_READ) || (job.c0 != 0) || (32'(job.rrow) >= ROWS);
      clr_r   <= '0;
      lc_r  <= WorkW'(job.c0); lr_r <= WorkW'(job.r0);
      lc1_r <= WorkW'(job.c1); lr1_r <= WorkW'(job.r1);
      dc_r  <= (job.c1 > job.c0) ? WorkW'(job.c1) - WorkW'(job.c0)
                                 : WorkW'(job.c0) - WorkW'(job.c1);
      dr_r  <= (job.r1 > job.r0) ? WorkW'(job.r1) - WorkW'(job.r0)
                                 : WorkW'(job.r0) - WorkW'(job.r1);
      sc_r  <= job.c0 < job.c1;
      sr_r  <= job.r0 < job.r1;
      err_r <= ((job.c1 > job.c0) ? WorkW'(job.c1) - WorkW'(job.c0)
                                  : WorkW'(job.c0) - WorkW'(job.c1))
             - ((job.r1 > job.r0) ? WorkW'(job.r1) - WorkW'(job.r0)
                                  : WorkW'(job.r0) - WorkW'(job.r1));
      ccc_r <= WorkW'(job.c0); ccr_r <= WorkW'(job.r0);
      cx_r  <= '0; cy_r <= WorkW'(job.c1);
      cd_r  <= WorkW'(1) - WorkW'(job.c1);
      oct_r <= '0;
    end else if (state_r == BK_LINE && !line_end && step_ok) begin
      if (e2 > -(WorkW+1)'(dr_r)) begin
        lc_r <= sc_r ? lc_r + WorkW'(1) : lc_r - WorkW'(1);
      end
      if (e2 < (WorkW+1)'(dc_r)) begin
        lr_r <= sr_r ? lr_r + WorkW'(1) : lr_r - WorkW'(1);
      end
      err_r <= err_r - ((e2 > -(WorkW+1)'(dr_r)) ? dr_r : '0)
                     + ((e2 < (WorkW+1)'(dc_r)) ? dc_r : '0);
    end else if (state_r == BK_CIRC && !circ_end) begin
      oct_r <= oct_r + 3'd1;
      if (oct_r == 3'd7) begin
        if (cd_r < 0) begin
          cd_r <= cd_r + {cx_r[WorkW-2:0], 1'b0} + WorkW'(3);
        end else begin
          cd_r <= cd_r + {cx_r[WorkW-2:0] - cy_r[WorkW-2:0], 1'b0} + WorkW'(5);
          cy_r <= cy_r - WorkW'(1);
        end
        cx_r <= cx_r + WorkW'(1);
      end
    end else if (state_r == BK_CLEAR) begin
      clr_r <= clr_r + 1'b1;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) res_push |-> state_r == BK_DONE)
    else $error("result outside done");
  assert property (@(posedge clk) disable iff (!rst_n) job_pop |=> state_r != BK_IDLE)
    else $error("job lost");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_CLEAR) |-> !p1_v_r) else $error("plot during clear");
endmodule
`default_nettype wire

@@ tb/srf_checker.sv @@
`default_nettype none
module srf_checker
  import srf_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     push,
  input  wire logic                     full,
  input  wire logic [2:0]               in_mode,
  input  wire logic signed [CoordW-1:0] in_first_col,
  input  wire logic signed [CoordW-1:0] in_first_row,
  input  wire logic signed [CoordW-1:0] in_second_col,
  input  wire logic signed [CoordW-1:0] in_second_row,
  input  wire logic signed [CoordW-1:0] in_third_col,
  input  wire logic signed [CoordW-1:0] in_third_row,
  input  wire logic signed [CoordW-1:0] in_radius,
  input  wire logic [4:0]               in_read_row,
  input  wire logic                     empty,
  input  wire logic                     pop,
  input  wire logic [63:0]              out_row_pixels,
  input  wire logic                     out_done_res,
  output int                            fail_count,
  output int                            pending,
  output int                            checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumRows = 32;
  localparam int NumCols = 64;

  typedef struct {
    logic [63:0] row_pixels;
    logic        done_res;
  } cmd_result_t;

  logic [63:0] pixel_map [NumRows];
  cmd_result_t result_q [$];

  // mark one pixel, off-canvas pixels are dropped
  function automatic void mark_dot(int row, int col);
    if (row >= 0 && row < NumRows && col >= 0 && col < NumCols)
      pixel_map[row][col] = 1'b1;
  endfunction

  // bresenham walk from (c0,r0) to (c1,r1)
  function automatic void draw_line(int c0, int r0, int c1, int r1);
    int dc, dr, sc, sr, err, e2;
    dc = (c1 > c0) ? c1 - c0 : c0 - c1;
    dr = (r1 > r0) ? r1 - r0 : r0 - r1;
    sc = (c0 < c1) ? 1 : -1;
    sr = (r0 < r1) ? 1 : -1;
    err = dc - dr;
    forever begin
      mark_dot(r0, c0);
      if (c0 == c1 && r0 == r1) break;
      e2 = 2 * err;
      if (e2 > -dr) begin
        err -= dr;
        c0 += sc;
      end
      if (e2 < dc) begin
        err += dc;
        r0 += sr;
      end
    end
  endfunction

  // midpoint circle, eight-way symmetric, decision starts at 1 - r
  function automatic void draw_circle(int cc, int cr, int rad);
    int x, y, d;
    x = 0;
    y = rad;
    d = 1 - rad;
    while (x <= y) begin
      mark_dot(cr + y, cc + x);
      mark_dot(cr - y, cc + x);
      mark_dot(cr + y, cc - x);
      mark_dot(cr - y, cc - x);
      mark_dot(cr + x, cc + y);
      mark_dot(cr - x, cc + y);
      mark_dot(cr + x, cc - y);
      mark_dot(cr - x, cc - y);
      if (d < 0) begin
        d += 2 * x + 3;
      end else begin
        d += 2 * (x - y) + 5;
        y--;
      end
      x++;
    end
  endfunction

  // apply one command to the canvas copy and give its result
  function automatic cmd_result_t apply_command(
    logic [2:0] mode, int c1, int r1, int c2, int r2, int c3, int r3, int rad,
    logic [4:0] rrow);
    cmd_result_t res;
    res.row_pixels = '0;
    res.done_res   = 1'b1;
    case (mode_t'(mode))
      MODE_CLEAR: begin
        foreach (pixel_map[i]) pixel_map[i] = '0;
      end
      MODE_LINE: begin
        draw_line(c1, r1, c2, r2);
      end
      MODE_RECT: begin
        draw_line(c1, r1, c2, r1);
        draw_line(c1, r2, c2, r2);
        draw_line(c1, r1, c1, r2);
        draw_line(c2, r1, c2, r2);
      end
      MODE_CIRCLE: begin
        draw_circle(c1, r1, rad);
      end
      MODE_TRI: begin
        draw_line(c1, r1, c2, r2);
        draw_line(c2, r2, c3, r3);
        draw_line(c3, r3, c1, r1);
      end
      MODE_READ: begin
        if (int'(rrow) < NumRows) res.row_pixels = pixel_map[rrow];
      end
      default: ;
    endcase
    return res;
  endfunction

  // watch both channels
  always @(posedge clk) begin
    cmd_result_t exp_res;
    if (!rst_n) begin
      foreach (pixel_map[i]) pixel_map[i] = '0;
      result_q.delete();
      fail_count = 0;
      checked = 0;
    end else begin
      // accepted command transaction
      if (push && !full)
        result_q.push_back(apply_command(in_mode, in_first_col, in_first_row,
          in_second_col, in_second_row, in_third_col, in_third_row, in_radius,
          in_read_row));
      // accepted result transaction
      if (pop && !empty) begin
        if (result_q.size() == 0) begin
          $error("result with no command waiting: row_pixels %h", out_row_pixels);
          fail_count++;
        end else begin
          exp_res = result_q.pop_front();
          checked++;
          if (out_row_pixels !== exp_res.row_pixels) begin
            $error("row_pixels expected %h actual %h", exp_res.row_pixels,
              out_row_pixels);
            fail_count++;
          end
          if (out_done_res !== exp_res.done_res) begin
            $error("done_res expected %b actual %b", exp_res.done_res, out_done_res);
            fail_count++;
          end
        end
      end
    end
    pending = result_q.size();
  end
endmodule
`default_nettype wire

@@ tb/testbench.sv @@
`default_nettype none
module testbench
  import srf_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     push = 1'b0;
  logic                     full;
  logic [2:0]               in_mode = '0;
  logic signed [CoordW-1:0] in_first_col = '0;
  logic signed [CoordW-1:0] in_first_row = '0;
  logic signed [CoordW-1:0] in_second_col = '0;
  logic signed [CoordW-1:0] in_second_row = '0;
  logic signed [CoordW-1:0] in_third_col = '0;
  logic signed [CoordW-1:0] in_third_row = '0;
  logic signed [CoordW-1:0] in_radius = '0;
  logic [4:0]               in_read_row = '0;
  logic                     empty;
  logic                     pop = 1'b0;
  logic [63:0]              out_row_pixels;
  logic                     out_done_res;
  int                       fail_count;
  int                       pending;
  int                       checked;
  int                       sent_cmds = 0;
  bit                       long_hold_seen = 1'b0;

  always #5 clk = ~clk;

  shape_rasterizer_framebuffer dut (.*);

  srf_checker u_checker (.*);

  // run limit
  initial begin
    #40ms;
    $display("FAIL shape_rasterizer_framebuffer");
    $finish;
  end

  // random gap length, mostly short, sometimes long
  function automatic int gap_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 93) return $urandom_range(1, 4);
    return $urandom_range(20, 120);
  endfunction

  // coordinate mostly near the canvas, now and then anywhere in range
  function automatic logic signed [CoordW-1:0] pick_coord(int hi);
    if ($urandom_range(0, 63) == 0) return CoordW'($urandom_range(0, 2047));
    return CoordW'($urandom_range(0, hi + 12) - 6);
  endfunction

  // offer one command transaction and wait until it is taken
  task automatic send_cmd(mode_t mode, int c1, int r1, int c2, int r2, int c3, int r3,
                          int rad, int rrow);
    int gap;
    bit took;
    gap = gap_len();
    repeat (gap) begin
      @(negedge clk);
      push <= 1'b0;
    end
    if (gap == 0 && sent_cmds == 0) @(negedge clk);
    push          <= 1'b1;
    in_mode       <= mode;
    in_first_col  <= CoordW'(c1);
    in_first_row  <= CoordW'(r1);
    in_second_col <= CoordW'(c2);
    in_second_row <= CoordW'(r2);
    in_third_col  <= CoordW'(c3);
    in_third_row  <= CoordW'(r3);
    in_radius     <= CoordW'(rad);
    in_read_row   <= 5'(rrow);
    do begin
      #0 took = !full;
      @(negedge clk);
    end while (!took);
    sent_cmds++;
  endtask

  // result side: random pop gaps plus one long hold-off
  initial begin
    int gap;
    int cycles;
    gap = 0;
    cycles = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      cycles++;
      if (cycles == 3000 && !long_hold_seen) begin
        long_hold_seen = 1'b1;
        gap = 4000;
      end
      if (gap > 0) begin
        pop <= 1'b0;
        gap--;
      end else begin
        pop <= 1'b1;
        if ($urandom_range(0, 7) == 0) gap = gap_len();
      end
    end
  end

  // stimulus
  initial begin
    int pick;
    mode_t m;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: every command, extremes, special cases
    send_cmd(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0);
    send_cmd(MODE_LINE, 0, 0, 63, 31, 0, 0, 0, 0);
    send_cmd(MODE_LINE, 5, 5, 5, 5, -1024, 1023, -1024, 31);
    send_cmd(MODE_READ, 1023, -1024, 1023, -1024, 1023, -1024, 1023, 5);
    send_cmd(MODE_LINE, -1024, -1024, 1023, 1023, 0, 0, 0, 0);
    send_cmd(MODE_RECT, 2, 3, 60, 28, 0, 0, 0, 0);
    send_cmd(MODE_RECT, 50, 30, -10, 40, 0, 0, 0, 0);
    send_cmd(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 3);
    send_cmd(MODE_CIRCLE, 30, 15, 0, 0, 0, 0, 10, 0);
    send_cmd(MODE_CIRCLE, 40, 8, 0, 0, 0, 0, 0, 0);
    send_cmd(MODE_CIRCLE, 20, 20, 0, 0, 0, 0, -1, 0);
    send_cmd(MODE_CIRCLE, 10, 10, 0, 0, 0, 0, -1024, 0);
    send_cmd(MODE_CIRCLE, 10, 10, 0, 0, 0, 0, 1023, 0);
    send_cmd(MODE_CIRCLE, -5, 70, 0, 0, 0, 0, 12, 0);
    send_cmd(MODE_TRI, 1, 1, 62, 10, 20, 31, 0, 0);
    send_cmd(MODE_TRI, -1024, 1023, 1023, -1024, 0, 0, 0, 0);
    send_cmd(MODE_NOP6, 1, 1, 60, 30, 3, 3, 5, 8);
    send_cmd(MODE_NOP7, -1, -1, -1, -1, -1, -1, -1, 31);
    send_cmd(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 15);
    send_cmd(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 31);
    send_cmd(MODE_CLEAR, 1023, 1023, 1023, 1023, 1023, 1023, 1023, 31);
    send_cmd(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 15);

    // random commands
    repeat (1300) begin
      pick = $urandom_range(0, 99);
      if (pick < 2) m = MODE_CLEAR;
      else if (pick < 20) m = MODE_LINE;
      else if (pick < 30) m = MODE_RECT;
      else if (pick < 42) m = MODE_CIRCLE;
      else if (pick < 52) m = MODE_TRI;
      else if (pick < 95) m = MODE_READ;
      else m = mode_t'($urandom_range(MODE_NOP6, MODE_NOP7));
      send_cmd(m, pick_coord(63), pick_coord(31), pick_coord(63), pick_coord(31),
        pick_coord(63), pick_coord(31),
        ($urandom_range(0, 63) == 0) ? $urandom_range(0, 2047) - 1024
                                     : $urandom_range(0, 40) - 3,
        $urandom_range(0, 31));
    end
    @(negedge clk);
    push <= 1'b0;

    // drain, then let the pipeline settle
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    $display("ran %0d commands, %0d results compared, long result stall applied: %0b",
      sent_cmds, checked, long_hold_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS shape_rasterizer_framebuffer");
    end else begin
      $display("FAIL shape_rasterizer_framebuffer");
    end
    $finish;
  end
endmodule
`default_nettype wire
